// ===== rtl/mrpu_pkg.sv =====
// Shared constants, types and helpers of the raw pixel unpacker.
`timescale 1ns / 1ps
`default_nettype none

package mrpu_pkg;

    // Frame geometry
    localparam int unsigned MAX_DIMENSION = 8192;
    localparam int unsigned DIM_W         = 14;
    localparam int unsigned COUNT_W       = 26;
    localparam int unsigned TOTAL_W       = 27;

    // Data widths
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PIX_W     = 16;
    localparam int unsigned GROUP_PIX = 4;
    localparam int unsigned GIDX_W    = 2;
    localparam int unsigned POS_W     = 3;

    // Group queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned Q_PTR_W     = 2;
    localparam int unsigned Q_CNT_W     = 3;

    // Configuration register indexes
    localparam logic [1:0] CFG_IDX_FORMAT = 2'd0;
    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

    // Packing formats; the unused code behaves as RAW16
    localparam logic [1:0] FMT_RAW10 = 2'd0;
    localparam logic [1:0] FMT_RAW12 = 2'd1;
    localparam logic [1:0] FMT_RAW16 = 2'd2;

    // One completed group: its pixels, index of the last one sent, frame end flag
    typedef struct packed {
        logic [GROUP_PIX-1:0][PIX_W-1:0] pix;
        logic [GIDX_W-1:0]               last_idx;
        logic                            frame_end;
    } t_group_rec;

    // Head of the group queue as seen by the back end
    typedef struct packed {
        logic       valid;
        t_group_rec head;
    } t_q_status;

    // Map zero to one and saturate at the largest frame dimension
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mrpu_front.sv =====
// Front end: configuration registers, byte gathering, pixel build and frame count.
`timescale 1ns / 1ps
`default_nettype none

module mrpu_front import mrpu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_push,
    input  wire logic [BYTE_W-1:0]  i_packed_byte,
    output logic                    o_full,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output t_group_rec              o_q_rec
);

    logic [1:0]         r_format;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [TOTAL_W-1:0] r_total;
    logic               r_cfg_hold;
    logic [POS_W-1:0]   r_byte_pos;
    logic [COUNT_W-1:0] r_emitted;
    logic [BYTE_W-1:0]  r_grp [GROUP_PIX];

    logic [TOTAL_W-1:0] n_total;
    logic [COUNT_W-1:0] n_emitted;
    logic               cfg_we;
    logic               accept;
    logic               group_done;
    logic [POS_W-1:0]   last_pos;
    logic [POS_W-1:0]   npix;
    logic [POS_W-1:0]   emit_cnt;
    logic [TOTAL_W-1:0] emitted_ext;
    logic [TOTAL_W-1:0] remain;
    logic               frame_end;
    logic [GROUP_PIX-1:0][PIX_W-1:0] pix;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    // Hold input off in the cycle after a write so the frame total settles
    assign o_full      = i_q_full | r_cfg_hold;
    assign accept      = i_push & ~o_full;

    // Group length and pixel count per format
    always_comb begin
        case (r_format)
            FMT_RAW10: begin
                last_pos = POS_W'(4);
                npix     = POS_W'(4);
            end
            FMT_RAW12: begin
                last_pos = POS_W'(2);
                npix     = POS_W'(2);
            end
            default: begin
                last_pos = POS_W'(1);
                npix     = POS_W'(1);
            end
        endcase
    end

    assign group_done = (r_byte_pos == last_pos);

    // Assemble pixels from the stored bytes and the closing byte
    always_comb begin
        pix = '0;
        case (r_format)
            FMT_RAW10: begin
                pix[0] = {6'd0, r_grp[0], i_packed_byte[7:6]};
                pix[1] = {6'd0, r_grp[1], i_packed_byte[5:4]};
                pix[2] = {6'd0, r_grp[2], i_packed_byte[3:2]};
                pix[3] = {6'd0, r_grp[3], i_packed_byte[1:0]};
            end
            FMT_RAW12: begin
                pix[0] = {4'd0, r_grp[0], i_packed_byte[7:4]};
                pix[1] = {4'd0, r_grp[1], i_packed_byte[3:0]};
            end
            default: begin
                pix[0] = {i_packed_byte, r_grp[0]};
            end
        endcase
    end

    // Clip the group against the pixels left in the frame
    always_comb begin
        emitted_ext = {1'b0, r_emitted};
        remain      = (emitted_ext < r_total) ? (r_total - emitted_ext) : '0;
        frame_end   = (remain <= TOTAL_W'(npix));
        emit_cnt    = frame_end ? remain[POS_W-1:0] : npix;
        n_emitted   = frame_end ? '0 : (r_emitted + COUNT_W'(npix));
    end

    assign o_q_push           = accept & group_done & (emit_cnt != '0);
    assign o_q_rec.pix        = pix;
    assign o_q_rec.last_idx   = GIDX_W'(emit_cnt - POS_W'(1));
    assign o_q_rec.frame_end  = frame_end;

    assign n_total = TOTAL_W'(clamp_dim(r_width)) * TOTAL_W'(clamp_dim(r_height));

    // Configuration, frame total and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format   <= FMT_RAW10;
            r_width    <= DIM_W'(1);
            r_height   <= DIM_W'(1);
            r_total    <= TOTAL_W'(1);
            r_cfg_hold <= 1'b0;
            r_byte_pos <= '0;
            r_emitted  <= '0;
        end else begin
            r_cfg_hold <= cfg_we;
            r_total    <= n_total;
            if (accept) begin
                if (group_done) begin
                    r_byte_pos <= '0;
                    r_emitted  <= n_emitted;
                end else begin
                    r_byte_pos <= r_byte_pos + POS_W'(1);
                end
            end
            if (cfg_we) begin
                case (i_cfg_index)
                    CFG_IDX_FORMAT: begin
                        r_format   <= i_cfg_data[1:0];
                        r_byte_pos <= '0;
                    end
                    CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Store the non-closing bytes of the group
    always_ff @(posedge i_clk) begin
        if (accept && !group_done) begin
            r_grp[r_byte_pos[GIDX_W-1:0]] <= i_packed_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mrpu_queue.sv =====
// Short queue of completed pixel groups between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module mrpu_queue import mrpu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_group_rec  i_rec,
    output logic             o_full,
    input  wire logic        i_pop,
    output t_q_status        o_status
);

    t_group_rec         r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full          = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_status.valid  = (r_count != '0);
    assign o_status.head   = r_mem[r_rd_ptr];
    assign do_push         = i_push & ~o_full;
    assign do_pop          = i_pop & o_status.valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Write the incoming group
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mrpu_back.sv =====
// Back end: steps through each queued group and presents one pixel at a time.
`timescale 1ns / 1ps
`default_nettype none

module mrpu_back import mrpu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_q_status   i_status,
    output logic             o_q_pop,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [PIX_W-1:0] o_pixel_value,
    output logic             o_group_last,
    output logic             o_frame_last
);

    logic [GIDX_W-1:0] r_sub;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_glast;
    logic              r_flast;

    logic load;
    logic sub_last;

    assign o_empty       = ~r_out_valid;
    assign o_pixel_value = r_pixel;
    assign o_group_last  = r_glast;
    assign o_frame_last  = r_flast;

    // Refill the output register when it is free or being taken
    assign load     = i_status.valid & (~r_out_valid | i_pop);
    assign sub_last = (r_sub == i_status.head.last_idx);
    assign o_q_pop  = load & sub_last;

    // Output valid and pixel index within the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_sub       <= sub_last ? '0 : (r_sub + GIDX_W'(1));
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= i_status.head.pix[r_sub];
            r_glast <= sub_last;
            r_flast <= sub_last & i_status.head.frame_end;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mipi_raw_pixel_unpacker.sv =====
// Top level of the RAW10/RAW12/RAW16 pixel unpacker.
//
//   Channel   Direction  Handshake               Payload
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//   bytes     in         i_push/o_full           i_packed_byte
//   pixels    out        o_empty/i_pop           o_pixel_value, o_group_last, o_frame_last
//
// Takes one byte per cycle while o_full is low; pixels leave one per cycle from the output
// register while i_pop is high and groups are queued. A closing byte queues its group,
// whose pixels pass to the output register. The four-entry queue sets how long the output
// may stall before o_full rises. A config write raises o_full in the next cycle while the
// frame total is recomputed. Synchronous reset clears all control state; no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module mipi_raw_pixel_unpacker import mrpu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    input  wire logic               i_push,
    input  wire logic [BYTE_W-1:0]  i_packed_byte,
    output logic                    o_full,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output logic [PIX_W-1:0]        o_pixel_value,
    output logic                    o_group_last,
    output logic                    o_frame_last
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    t_group_rec q_rec;
    t_q_status  q_status;

    mrpu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (i_push),
        .i_packed_byte (i_packed_byte),
        .o_full        (o_full),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_rec       (q_rec)
    );

    mrpu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_rec    (q_rec),
        .o_full   (q_full),
        .i_pop    (q_pop),
        .o_status (q_status)
    );

    mrpu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_status      (q_status),
        .o_q_pop       (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_pixel_value (o_pixel_value),
        .o_group_last  (o_group_last),
        .o_frame_last  (o_frame_last)
    );

endmodule

`default_nettype wire

// ===== rtl/mrpu_checker.sv =====
// Port-level checks of the raw pixel unpacker and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mrpu_checker import mrpu_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready,
    input wire logic               o_full,
    input wire logic               o_empty,
    input wire logic               i_pop,
    input wire logic [PIX_W-1:0]   o_pixel_value,
    input wire logic               o_group_last,
    input wire logic               o_frame_last
);

    // Reset leaves no pixel waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("pixel waiting right after reset");

    // A config transfer blocks byte input for the next cycle
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> o_full)
        else $error("byte accepted right after a config transfer");

    // The last pixel of a frame also closes its group
    a_frame_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_frame_last) |-> o_group_last)
        else $error("frame end on a pixel that is not the last of its group");

    // A stalled pixel holds its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_pixel_value)
            && $stable(o_group_last) && $stable(o_frame_last)))
        else $error("pixel changed while stalled");

endmodule

bind mipi_raw_pixel_unpacker mrpu_checker u_mrpu_checker (.*);

`default_nettype wire
